>>> rtl/core/ppwf_pkg.sv
// ----------------------------------------------------------------------------
// ppwf_pkg
// Shared constants, types and codes of the pulse peak window features unit.
// ----------------------------------------------------------------------------
package ppwf_pkg;

    // pulse shape
    localparam int SLICES      = 10;
    localparam int SAMPLE_BITS = 16;

    // fixed field widths
    localparam int IN_W      = 16;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int SUM_W     = 20;
    localparam int PEAK_W    = 16;
    localparam int PSL_W     = 4;
    localparam int WSL_W     = 12;
    localparam int FRAC_W    = 8;

    // derived widths
    localparam int IDX_W   = $clog2(SLICES);
    localparam int CNT_W   = $clog2(SLICES + 1);
    localparam int WS_W    = SAMPLE_BITS + CNT_W;
    localparam int WN_W    = WS_W + IDX_W;
    localparam int WIN_W   = ((IDX_W > CFG_W) ? IDX_W : CFG_W) + 1;
    localparam int DSTEP_W = $clog2(WSL_W + 1);

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MID_FIRST  = 2'd0,
        CFG_MID_LAST   = 2'd1,
        CFG_WIN_BEFORE = 2'd2,
        CFG_WIN_AFTER  = 2'd3
    } t_cfg_idx;

    // top level sequencer
    typedef enum logic [1:0] {
        ST_COLLECT,
        ST_SWEEP,
        ST_DIVIDE,
        ST_OUTPUT
    } t_state;

    // running pulse figures including the current beat
    typedef struct packed {
        logic [SUM_W-1:0]       mid_sum;
        logic [SUM_W-1:0]       total_sum;
        logic [SAMPLE_BITS-1:0] peak;
        logic [IDX_W-1:0]       peak_slice;
    } t_pulse;

    // window sums handed to the divider
    typedef struct packed {
        logic [WS_W-1:0] wsum;
        logic [WN_W-1:0] wnum;
    } t_win;

endpackage

>>> rtl/core/ppwf_accum.sv
// ----------------------------------------------------------------------------
// ppwf_accum
// Slice counter with running middle sum, total sum and peak search.
// ----------------------------------------------------------------------------
module ppwf_accum (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_beat,
    input  logic [ppwf_pkg::SAMPLE_BITS-1:0]    i_sample,
    input  logic [ppwf_pkg::CFG_W-1:0]          i_mid_first,
    input  logic [ppwf_pkg::CFG_W-1:0]          i_mid_last,
    output logic [ppwf_pkg::IDX_W-1:0]          o_slice,
    output logic                                o_last,
    output ppwf_pkg::t_pulse                    o_pulse
);

    localparam int ACC_W = ((ppwf_pkg::SAMPLE_BITS > ppwf_pkg::SUM_W) ?
                            ppwf_pkg::SAMPLE_BITS : ppwf_pkg::SUM_W) + 1;
    localparam logic [ppwf_pkg::SUM_W-1:0] SUM_MAX = {ppwf_pkg::SUM_W{1'b1}};

    function automatic logic [ppwf_pkg::SUM_W-1:0] sat_add(
        input logic [ppwf_pkg::SUM_W-1:0]       a,
        input logic [ppwf_pkg::SAMPLE_BITS-1:0] b
    );
        logic [ACC_W-1:0] s;
        s = ACC_W'(a) + ACC_W'(b);
        return (s > ACC_W'(SUM_MAX)) ? SUM_MAX : s[ppwf_pkg::SUM_W-1:0];
    endfunction

    logic [ppwf_pkg::IDX_W-1:0]       r_count;
    logic [ppwf_pkg::SUM_W-1:0]       r_mid, n_mid;
    logic [ppwf_pkg::SUM_W-1:0]       r_total, n_total;
    logic [ppwf_pkg::SAMPLE_BITS-1:0] r_peak, n_peak;
    logic [ppwf_pkg::IDX_W-1:0]       r_peak_slice, n_peak_slice;
    logic                             in_mid;

    // running figures with the current sample folded in
    always_comb begin
        in_mid = (ppwf_pkg::WIN_W'(r_count) >= ppwf_pkg::WIN_W'(i_mid_first)) &&
                 (ppwf_pkg::WIN_W'(r_count) <= ppwf_pkg::WIN_W'(i_mid_last));
        n_mid   = in_mid ? sat_add(r_mid, i_sample) : r_mid;
        n_total = sat_add(r_total, i_sample);
        if (i_sample > r_peak) begin
            n_peak       = i_sample;
            n_peak_slice = r_count;
        end else begin
            n_peak       = r_peak;
            n_peak_slice = r_peak_slice;
        end
    end

    assign o_slice = r_count;
    assign o_last  = (r_count == ppwf_pkg::IDX_W'(ppwf_pkg::SLICES - 1));
    assign o_pulse = '{mid_sum: n_mid, total_sum: n_total, peak: n_peak,
                       peak_slice: n_peak_slice};

    // running state, cleared after the last slice of a pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_mid        <= '0;
            r_total      <= '0;
            r_peak       <= '0;
            r_peak_slice <= '0;
        end else if (i_beat) begin
            if (o_last) begin
                r_count      <= '0;
                r_mid        <= '0;
                r_total      <= '0;
                r_peak       <= '0;
                r_peak_slice <= '0;
            end else begin
                r_count      <= r_count + 1'b1;
                r_mid        <= n_mid;
                r_total      <= n_total;
                r_peak       <= n_peak;
                r_peak_slice <= n_peak_slice;
            end
        end
    end

endmodule

>>> rtl/core/ppwf_window.sv
// ----------------------------------------------------------------------------
// ppwf_window
// Slice store and window sweep: reads the window one slice a cycle and
// accumulates charge and slice-weighted charge.
// ----------------------------------------------------------------------------
module ppwf_window (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_wr_en,
    input  logic [ppwf_pkg::IDX_W-1:0]          i_wr_addr,
    input  logic [ppwf_pkg::SAMPLE_BITS-1:0]    i_wr_data,
    input  logic                                i_start,
    input  logic [ppwf_pkg::IDX_W-1:0]          i_peak_slice,
    input  logic [ppwf_pkg::CFG_W-1:0]          i_before,
    input  logic [ppwf_pkg::CFG_W-1:0]          i_after,
    output logic                                o_done,
    output ppwf_pkg::t_win                      o_win
);

    logic [ppwf_pkg::SAMPLE_BITS-1:0] mem [ppwf_pkg::SLICES];

    logic                             r_busy;
    logic [ppwf_pkg::IDX_W-1:0]       r_addr;
    logic [ppwf_pkg::IDX_W-1:0]       r_hi;
    logic                             r_rd_vld;
    logic                             r_rd_last;
    logic [ppwf_pkg::IDX_W-1:0]       r_rd_t;
    logic [ppwf_pkg::SAMPLE_BITS-1:0] r_rd_data;
    logic [ppwf_pkg::WS_W-1:0]        r_wsum;
    logic [ppwf_pkg::WN_W-1:0]        r_wnum;
    logic                             r_done;

    logic [ppwf_pkg::WIN_W-1:0] pk, lo, hi_raw, hi;

    // window bounds clipped to the pulse
    always_comb begin
        pk     = ppwf_pkg::WIN_W'(i_peak_slice);
        lo     = (pk >= ppwf_pkg::WIN_W'(i_before)) ? pk - ppwf_pkg::WIN_W'(i_before) : '0;
        hi_raw = pk + ppwf_pkg::WIN_W'(i_after);
        hi     = (hi_raw > ppwf_pkg::WIN_W'(ppwf_pkg::SLICES - 1)) ?
                 ppwf_pkg::WIN_W'(ppwf_pkg::SLICES - 1) : hi_raw;
    end

    // slice store, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= mem[r_addr];
    end

    // read sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_rd_last <= 1'b0;
            r_done    <= 1'b0;
            r_addr    <= '0;
        end else begin
            r_rd_vld  <= r_busy;
            r_rd_last <= r_busy && (r_addr == r_hi);
            r_done    <= r_rd_vld && r_rd_last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_addr <= lo[ppwf_pkg::IDX_W-1:0];
            end else if (r_busy) begin
                if (r_addr == r_hi) begin
                    r_busy <= 1'b0;
                end else begin
                    r_addr <= r_addr + 1'b1;
                end
            end
        end
    end

    // window bound and slice tag of the beat in flight
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_hi <= hi[ppwf_pkg::IDX_W-1:0];
        end
        r_rd_t <= r_addr;
    end

    // charge and weighted charge accumulators
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_wsum <= '0;
            r_wnum <= '0;
        end else if (r_rd_vld) begin
            r_wsum <= r_wsum + ppwf_pkg::WS_W'(r_rd_data);
            r_wnum <= r_wnum + ppwf_pkg::WN_W'(r_rd_t) * ppwf_pkg::WN_W'(r_rd_data);
        end
    end

    assign o_done = r_done;
    assign o_win  = '{wsum: r_wsum, wnum: r_wnum};

endmodule

>>> rtl/core/ppwf_div.sv
// ----------------------------------------------------------------------------
// ppwf_div
// Restoring divider for the weighted mean slice, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module ppwf_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  ppwf_pkg::t_win                i_win,
    output logic                          o_done,
    output logic [ppwf_pkg::WSL_W-1:0]    o_quot,
    output logic                          o_empty
);

    localparam int NW = ppwf_pkg::WN_W + ppwf_pkg::FRAC_W;

    logic                          r_busy;
    logic                          r_done;
    logic [ppwf_pkg::DSTEP_W-1:0]  r_step;
    logic [ppwf_pkg::WS_W-1:0]     r_den;
    logic [ppwf_pkg::WS_W:0]       r_rem;
    logic [ppwf_pkg::WSL_W-1:0]    r_bits;
    logic [ppwf_pkg::WSL_W-1:0]    r_quot;

    logic [NW-1:0]             num;
    logic [ppwf_pkg::WS_W:0]   rem0;
    logic [ppwf_pkg::WS_W:0]   sh;
    logic                      ge;

    // numerator scaled by 256; the mean stays below 16 so the top part
    // is already below the divisor
    always_comb begin
        num  = {i_win.wnum, ppwf_pkg::FRAC_W'(0)};
        rem0 = (ppwf_pkg::WS_W + 1)'(num >> ppwf_pkg::WSL_W);
        sh   = {r_rem[ppwf_pkg::WS_W-1:0], r_bits[ppwf_pkg::WSL_W-1]};
        ge   = (sh >= {1'b0, r_den});
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= ppwf_pkg::DSTEP_W'(ppwf_pkg::WSL_W);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == ppwf_pkg::DSTEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // compare and subtract
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den  <= i_win.wsum;
            r_rem  <= rem0;
            r_bits <= num[ppwf_pkg::WSL_W-1:0];
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= ge ? sh - {1'b0, r_den} : sh;
            r_bits <= {r_bits[ppwf_pkg::WSL_W-2:0], 1'b0};
            r_quot <= {r_quot[ppwf_pkg::WSL_W-2:0], ge};
        end
    end

    assign o_done  = r_done;
    assign o_empty = (r_den == '0);
    assign o_quot  = o_empty ? '0 : r_quot;

endmodule

>>> rtl/core/pulse_peak_window_features_unit.sv
// ----------------------------------------------------------------------------
// pulse_peak_window_features_unit
// Peak finder with middle and total sums, windowed charge and weighted slice.
// ----------------------------------------------------------------------------
// Usage:
//   Samples of one pulse arrive on the input channel (i_valid / o_ready),
//   SLICES beats per pulse, one beat per cycle while collecting. After the
//   last slice the unit sweeps the charge window through the slice store,
//   one slice a cycle, then runs a 12-step divider for the weighted slice.
//   One result beat per pulse leaves on the output channel (o_valid /
//   i_ready) from an output register.
//   The window sweep over the store's single read port and the divider
//   bound the pulse rate; a new pulse is taken only after its result loads.
//   Input is held off (o_ready low) during sweep, divide and output. A stalled
//   receiver holds the result in the output register while the next pulse
//   is collected; a second result then waits until the register frees.
//   Reset clears the running sums, slice counter and output valid and
//   loads the register defaults; the slice store needs no clearing.
//   Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data.
// ----------------------------------------------------------------------------
module pulse_peak_window_features_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ppwf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ppwf_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [ppwf_pkg::IN_W-1:0]         i_sample,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [ppwf_pkg::SUM_W-1:0]        o_mid_sum,
    output logic [ppwf_pkg::SUM_W-1:0]        o_total_sum,
    output logic [ppwf_pkg::PEAK_W-1:0]       o_peak_value,
    output logic [ppwf_pkg::PSL_W-1:0]        o_peak_slice,
    output logic [ppwf_pkg::SUM_W-1:0]        o_window_sum,
    output logic [ppwf_pkg::WSL_W-1:0]        o_weighted_slice,
    output logic                              o_empty_window
);

    localparam int PKX_W = (ppwf_pkg::SAMPLE_BITS > ppwf_pkg::PEAK_W) ?
                           ppwf_pkg::SAMPLE_BITS : ppwf_pkg::PEAK_W;
    localparam int WSX_W = (ppwf_pkg::WS_W > ppwf_pkg::SUM_W) ?
                           ppwf_pkg::WS_W : ppwf_pkg::SUM_W;
    localparam logic [ppwf_pkg::PEAK_W-1:0] PEAK_MAX = {ppwf_pkg::PEAK_W{1'b1}};
    localparam logic [ppwf_pkg::SUM_W-1:0]  SUM_MAX  = {ppwf_pkg::SUM_W{1'b1}};

    // configuration registers
    logic [ppwf_pkg::CFG_W-1:0] r_mid_first, r_mid_last, r_win_before, r_win_after;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_first  <= ppwf_pkg::CFG_W'(1);
            r_mid_last   <= ppwf_pkg::CFG_W'(4);
            r_win_before <= ppwf_pkg::CFG_W'(1);
            r_win_after  <= ppwf_pkg::CFG_W'(2);
        end else if (i_cfg_we) begin
            unique case (ppwf_pkg::t_cfg_idx'(i_cfg_idx))
                ppwf_pkg::CFG_MID_FIRST:  r_mid_first  <= i_cfg_data;
                ppwf_pkg::CFG_MID_LAST:   r_mid_last   <= i_cfg_data;
                ppwf_pkg::CFG_WIN_BEFORE: r_win_before <= i_cfg_data;
                ppwf_pkg::CFG_WIN_AFTER:  r_win_after  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ppwf_pkg::t_state r_state, n_state;

    logic [ppwf_pkg::SAMPLE_BITS-1:0] sample;
    logic                             in_beat;
    logic                             last_slice;
    logic [ppwf_pkg::IDX_W-1:0]       slice;
    ppwf_pkg::t_pulse                 pulse;
    ppwf_pkg::t_pulse                 r_pulse;
    logic                             win_start;
    logic                             win_done;
    ppwf_pkg::t_win                   win;
    logic                             div_start;
    logic                             div_done;
    logic [ppwf_pkg::WSL_W-1:0]       quot;
    logic                             empty;
    logic                             out_load;
    logic                             r_out_vld;

    assign sample    = ppwf_pkg::SAMPLE_BITS'(i_sample);
    assign in_beat   = i_valid && o_ready;
    assign win_start = in_beat && last_slice;

    // running sums and peak
    ppwf_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_beat      (in_beat),
        .i_sample    (sample),
        .i_mid_first (r_mid_first),
        .i_mid_last  (r_mid_last),
        .o_slice     (slice),
        .o_last      (last_slice),
        .o_pulse     (pulse)
    );

    // slice store and window sweep
    ppwf_window u_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr_en      (in_beat),
        .i_wr_addr    (slice),
        .i_wr_data    (sample),
        .i_start      (win_start),
        .i_peak_slice (pulse.peak_slice),
        .i_before     (r_win_before),
        .i_after      (r_win_after),
        .o_done       (win_done),
        .o_win        (win)
    );

    // weighted mean slice divider
    ppwf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_win   (win),
        .o_done  (div_done),
        .o_quot  (quot),
        .o_empty (empty)
    );

    // pulse figures held for the result
    always_ff @(posedge i_clk) begin
        if (win_start) begin
            r_pulse <= pulse;
        end
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ppwf_pkg::ST_COLLECT;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencer next state and strobes
    always_comb begin
        n_state   = r_state;
        o_ready   = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (r_state)
            ppwf_pkg::ST_COLLECT: begin
                o_ready = 1'b1;
                if (i_valid && last_slice) begin
                    n_state = ppwf_pkg::ST_SWEEP;
                end
            end
            ppwf_pkg::ST_SWEEP: begin
                if (win_done) begin
                    div_start = 1'b1;
                    n_state   = ppwf_pkg::ST_DIVIDE;
                end
            end
            ppwf_pkg::ST_DIVIDE: begin
                if (div_done) begin
                    n_state = ppwf_pkg::ST_OUTPUT;
                end
            end
            ppwf_pkg::ST_OUTPUT: begin
                if (!r_out_vld || i_ready) begin
                    out_load = 1'b1;
                    n_state  = ppwf_pkg::ST_COLLECT;
                end
            end
            default: n_state = ppwf_pkg::ST_COLLECT;
        endcase
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    // output payload with saturation to the field widths
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_mid_sum        <= r_pulse.mid_sum;
            o_total_sum      <= r_pulse.total_sum;
            o_peak_value     <= (PKX_W'(r_pulse.peak) > PKX_W'(PEAK_MAX)) ?
                                PEAK_MAX : ppwf_pkg::PEAK_W'(r_pulse.peak);
            o_peak_slice     <= ppwf_pkg::PSL_W'(r_pulse.peak_slice);
            o_window_sum     <= (WSX_W'(win.wsum) > WSX_W'(SUM_MAX)) ?
                                SUM_MAX : ppwf_pkg::SUM_W'(win.wsum);
            o_weighted_slice <= quot;
            o_empty_window   <= empty;
        end
    end

    assign o_valid = r_out_vld;

    // window sweep finishes only while the sequencer waits for it
    a_win_done_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        win_done |-> (r_state == ppwf_pkg::ST_SWEEP))
        else $error("window done outside sweep");

    // divider finishes only while the sequencer waits for it
    a_div_done_in_divide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ppwf_pkg::ST_DIVIDE))
        else $error("divider done outside divide");

    // last slice of a pulse starts the sweep and closes the input
    a_last_starts_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        win_start |=> (r_state == ppwf_pkg::ST_SWEEP) && !o_ready)
        else $error("last slice did not start sweep");

    // a loaded result shows up on the output channel
    a_load_shows_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> o_valid)
        else $error("loaded result not valid");

endmodule
